// File: hdl/sha256_pkg.sv
// sha256_pkg: shared constants, types and round functions for the sha-256 digest block
// holds the round constant table, the initial hash values and the sequencer state type
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

  localparam int unsigned NumRounds   = 64;
  localparam int unsigned NumHashWords = 8;
  localparam int unsigned WinWords    = 16;
  localparam int unsigned CountBits   = 61;

  // position in a 64-byte block where the bit length starts
  localparam logic [5:0] LenStartPos = 6'd56;
  localparam logic [5:0] LastBytePos = 6'd63;
  localparam logic [7:0] PadMarkByte = 8'h80;
  localparam logic [2:0] LastWordIdx = 3'd7;

  localparam logic [31:0] ROUND_K [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [NumHashWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ROUND  = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_PAD    = 5'b01000,
    ST_EMIT   = 5'b10000
  } seq_state_t;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

// File: hdl/sha256_message_digest.sv
// sha256_message_digest: byte-serial sha-256 digest engine, top level
// one shared round unit driven by a small sequencer; depends on sha256_pkg
`timescale 1ns / 1ps
`default_nettype none

// usage
// - message channel (msg_valid / msg_ready): one item per message byte, with
//   byte_present marking a real byte and message_end closing the message;
//   an item with message_end and no byte finishes the message as it stands
//   (an empty message is a single such item)
// - digest channel (digest_valid / digest_ready): eight items per message,
//   word_index 0 first, digest_last high on word 7
// - a byte that does not fill the 64-byte block leaves msg_ready high; the
//   byte that fills a block starts the rounds and the hash update on the
//   single round unit, and msg_ready stays low until both are done
// - message end: padding shifts in one byte per cycle from the current fill
//   position to the block end, then the block is compressed; when the fill
//   position is 56 or more a second pad block and its compression follow
// - the digest words then wait in the hash registers; msg_ready stays low
//   until the last word is taken, so a stalled receiver simply holds the
//   block in its output phase with the payload steady
// - reset (rst, synchronous, active high) loads the initial hash values,
//   clears the byte count and returns to idle; no clearing pass is needed
module sha256_message_digest
  import sha256_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // message channel
  input  wire logic        msg_valid,
  output logic             msg_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_present,
  input  wire logic        message_end,
  // digest channel
  output logic             digest_valid,
  input  wire logic        digest_ready,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             digest_last
);

  // sequencer
  seq_state_t state;
  seq_state_t ret_state;       // where to go after the hash update

  // message buffer and schedule window share one 16-word shift line
  logic [31:0] win [WinWords];
  logic [31:0] hash [NumHashWords];
  logic [31:0] v [NumHashWords];  // working variables a..h
  logic [5:0]  round;
  logic [CountBits-1:0] count;
  logic [CountBits-1:0] count_next;

  // padding control
  logic [5:0]  ppos;           // fill position of the next pad byte
  logic        pad_first;      // next pad byte is the 0x80 marker
  logic        len_ok;         // this pad block carries the bit length
  logic [63:0] len;            // bit length, consumed msb first

  logic [2:0]  out_idx;

  logic        msg_acc;
  logic        dig_acc;
  logic        shift_en;
  logic [7:0]  shift_byte;
  logic [7:0]  pad_byte;
  logic        len_byte;

  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;

  assign msg_ready    = (state == ST_IDLE);
  assign digest_valid = (state == ST_EMIT);
  assign msg_acc      = msg_valid && msg_ready;
  assign dig_acc      = digest_valid && digest_ready;

  assign digest_word = hash[0];
  assign word_index  = out_idx;
  assign digest_last = (out_idx == LastWordIdx);

  assign count_next = byte_present ? count + 1'b1 : count;

  // pad byte: marker first, bit length in the last eight places of the final block
  assign len_byte = len_ok && (ppos >= LenStartPos);
  always_comb begin
    if (pad_first) begin
      pad_byte = PadMarkByte;
    end else if (len_byte) begin
      pad_byte = len[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign shift_en   = (msg_acc && byte_present) || (state == ST_PAD);
  assign shift_byte = (state == ST_PAD) ? pad_byte : data_byte;

  // shared round unit: one compression round and one schedule word per cycle
  assign w_new = small_sig1(win[14]) + win[9] + small_sig0(win[1]) + win[0];
  assign t1    = v[7] + big_sig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
               + ROUND_K[round] + win[0];
  assign t2    = big_sig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  // shift line: bytes enter at win[15], rounds pull words from win[0]
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < WinWords - 1; i++) begin
        win[i] <= {win[i][23:0], win[i+1][31:24]};
      end
      win[WinWords-1] <= {win[WinWords-1][23:0], shift_byte};
    end else if (state == ST_ROUND) begin
      for (int i = 0; i < WinWords - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[WinWords-1] <= w_new;
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    if (state == ST_ROUND) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end else begin
      // preload with the chaining value while waiting for a full block
      for (int i = 0; i < NumHashWords; i++) begin
        v[i] <= hash[i];
      end
    end
  end

  // padding length register
  always_ff @(posedge clk) begin
    if (msg_acc && message_end) begin
      len <= {count_next, 3'b000};
    end else if (state == ST_PAD && !pad_first && len_byte) begin
      len <= {len[55:0], 8'h00};
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret_state <= ST_IDLE;
      round     <= '0;
      count     <= '0;
      ppos      <= '0;
      pad_first <= 1'b0;
      len_ok    <= 1'b0;
      out_idx   <= '0;
      for (int i = 0; i < NumHashWords; i++) begin
        hash[i] <= INIT_HASH[i];
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (msg_acc) begin
            count <= count_next;
            if (message_end) begin
              ppos      <= count_next[5:0];
              pad_first <= 1'b1;
              len_ok    <= 1'b0;
            end
            if (byte_present && count[5:0] == LastBytePos) begin
              // block full: compress before anything else
              state     <= ST_ROUND;
              round     <= '0;
              ret_state <= message_end ? ST_PAD : ST_IDLE;
            end else if (message_end) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          ppos      <= ppos + 1'b1;
          pad_first <= 1'b0;
          if ((pad_first && ppos < LenStartPos) || ppos == LastBytePos) begin
            len_ok <= 1'b1;
          end
          if (ppos == LastBytePos) begin
            state     <= ST_ROUND;
            round     <= '0;
            ret_state <= len_ok ? ST_EMIT : ST_PAD;
          end
        end
        ST_ROUND: begin
          round <= round + 1'b1;
          if (round == 6'(NumRounds - 1)) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          for (int i = 0; i < NumHashWords; i++) begin
            hash[i] <= hash[i] + v[i];
          end
          out_idx <= '0;
          state   <= ret_state;
        end
        ST_EMIT: begin
          if (dig_acc) begin
            out_idx <= out_idx + 1'b1;
            if (out_idx == LastWordIdx) begin
              // digest done: back to the initial chaining value
              for (int i = 0; i < NumHashWords; i++) begin
                hash[i] <= INIT_HASH[i];
              end
              count <= '0;
              state <= ST_IDLE;
            end else begin
              for (int i = 0; i < NumHashWords - 1; i++) begin
                hash[i] <= hash[i+1];
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // never take a message item while digest words are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(msg_ready && digest_valid))
    else $error("message and digest channels active together");

  // every compression starts at round zero
  a_round_start: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_ROUND) |-> (round == '0))
    else $error("compression entered mid-round");

  // after the last digest word the block is ready for a new message
  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    (dig_acc && digest_last) |=> (msg_ready && count == '0))
    else $error("block not idle after last digest word");

  // output phase always starts at word zero
  a_emit_start: assert property (@(posedge clk) disable iff (rst)
    $rose(digest_valid) |-> (word_index == '0))
    else $error("digest output did not start at word zero");

endmodule

`default_nettype wire
